>>> rtl/rpa_pkg.sv
`timescale 1ns / 1ps
// Package for the reference-counted page allocator: field widths, request and
// status codes, sequencer states and register map constants. No dependencies.
package rpa_pkg;

   localparam int PAGE_IN_W  = 16;  // width of the request page index
   localparam int PAGE_OUT_W = 15;  // width of the result page and stack entries
   localparam int REF_OUT_W  = 8;   // width of the reported and requested counts
   localparam int FUP_W      = 15;  // width of the first usable page register

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_FIRST_USABLE = 1'b0;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_SET   = 2'd2,
      KIND_GET   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_FREE  = 2'd1,
      STAT_INVALID  = 2'd2,
      STAT_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

endpackage

>>> rtl/rpa_req_if.sv
`timescale 1ns / 1ps
// Request channel of the page allocator: valid/ready handshake and payload.
// Depends on rpa_pkg.
interface rpa_req_if;
   logic                             valid;
   logic                             ready;
   rpa_pkg::kind_type                kind;
   logic [rpa_pkg::PAGE_IN_W-1:0]    page_index;
   logic [rpa_pkg::REF_OUT_W-1:0]    ref_value;

   modport source (output valid, kind, page_index, ref_value, input ready);
   modport sink   (input valid, kind, page_index, ref_value, output ready);
endinterface

>>> rtl/rpa_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the page allocator: valid/ready handshake and payload.
// Depends on rpa_pkg.
interface rpa_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rpa_pkg::PAGE_OUT_W-1:0]   page_out;
   logic [rpa_pkg::REF_OUT_W-1:0]    use_count;
   rpa_pkg::status_type              status;
   logic                             released;

   modport source (output valid, page_out, use_count, status, released, input ready);
   modport sink   (input valid, page_out, use_count, status, released, output ready);
endinterface

>>> rtl/rpa_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module rpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rpa_csr.sv
`timescale 1ns / 1ps
// APB-style configuration register block holding the first usable page.
// Depends on rpa_pkg.
module rpa_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rpa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rpa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rpa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [rpa_pkg::FUP_W-1:0]         first_usable_page
);
   import rpa_pkg::*;

   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_hit;
   logic [FUP_W-1:0]     fup_ff;
   logic [FUP_W-1:0]     fup_in;

   // Registers are word aligned; the low two address bits are ignored.
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite
                       && (reg_idx == CSR_IDX_FIRST_USABLE);

   always_comb begin
      fup_in = fup_ff;
      if (wr_hit) begin
         fup_in = csr_pwdata[FUP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fup_ff <= '0;
      end else begin
         fup_ff <= fup_in;
      end
   end

   assign csr_prdata = (reg_idx == CSR_IDX_FIRST_USABLE) ? CSR_DATA_W'(fup_ff) : '0;
   assign first_usable_page = fup_ff;

endmodule

>>> rtl/refcounted_page_allocator.sv
`timescale 1ns / 1ps
// Reference-counted page allocator: LIFO free stack and per-page counts in two RAMs.
// An accepted transaction reads both RAMs, then in the execute state writes back
// and registers its result once the result register has room; no new request is
// taken until then. Reset is synchronous; after it a clearing pass zeroes the count
// RAM while requests wait (CSR writes go on).
// Depends on rpa_pkg, rpa_req_if, rpa_rsp_if, rpa_ram and rpa_csr.
module refcounted_page_allocator #(
   parameter int NUM_PAGES = 32768,
   parameter int REF_BITS  = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   rpa_req_if.sink                           req_ch,
   rpa_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rpa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rpa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rpa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import rpa_pkg::*;

   // Address width of both RAMs, and width of the free count, which must be able
   // to hold NUM_PAGES itself when the stack is full.
   localparam int AW     = $clog2(NUM_PAGES);
   localparam int CW     = $clog2(NUM_PAGES + 1);
   // Widened page forms so that the RAM address can always be part-selected.
   localparam int EXT_W  = (AW > PAGE_IN_W) ? AW : PAGE_IN_W;
   localparam int PEXT_W = (AW > PAGE_OUT_W) ? AW : PAGE_OUT_W;
   localparam int MAXW   = (REF_BITS > REF_OUT_W) ? REF_BITS : REF_OUT_W;

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   logic [FUP_W-1:0] first_usable_page;

   rpa_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready),
      .first_usable_page (first_usable_page)
   );

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic [CW-1:0]        free_count_ff, free_count_in;

   // Request captured at acceptance, used during the execute state.
   kind_type             kind_ff;
   logic [PAGE_IN_W-1:0] page_ff;
   logic [REF_OUT_W-1:0] val_ff;
   logic                 in_range_ff;

   // Output register that decouples the result channel from the sequencer.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PAGE_OUT_W-1:0] rsp_page_ff;
   logic [REF_OUT_W-1:0]  rsp_cnt_ff;
   status_type            rsp_status_ff;
   logic                  rsp_rel_ff;

   // ------------------------------------------------------------------
   // RAM ports
   // ------------------------------------------------------------------
   logic                  stk_wr_en, stk_rd_en;
   logic [AW-1:0]         stk_wr_addr, stk_rd_addr;
   logic [PAGE_OUT_W-1:0] stk_wr_data, stk_rd_data;

   logic                  ref_wr_en, ref_rd_en;
   logic [AW-1:0]         ref_wr_addr, ref_rd_addr;
   logic [REF_BITS-1:0]   ref_wr_data, ref_rd_data;

   rpa_ram #(.WIDTH(PAGE_OUT_W), .DEPTH(NUM_PAGES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   rpa_ram #(.WIDTH(REF_BITS), .DEPTH(NUM_PAGES)) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_wr_en),
      .wr_addr (ref_wr_addr),
      .wr_data (ref_wr_data),
      .rd_en   (ref_rd_en),
      .rd_addr (ref_rd_addr),
      .rd_data (ref_rd_data)
   );

   // ------------------------------------------------------------------
   // Read addresses. Both RAMs are read at the acceptance edge: the count of
   // the requested page, and the top of the stack for a possible allocate.
   // The previous transaction wrote back as it left the execute state, so no
   // forwarding is needed.
   // ------------------------------------------------------------------
   logic [EXT_W-1:0]  req_page_ext;
   logic [EXT_W-1:0]  page_ff_ext;
   logic [CW-1:0]     count_m1;
   logic              req_in_range;
   logic              req_fire;
   logic              out_free;

   assign req_page_ext = EXT_W'(req_ch.page_index);
   assign page_ff_ext  = EXT_W'(page_ff);
   assign count_m1     = free_count_ff - 1'b1;
   assign req_in_range = (32'(req_ch.page_index) < NUM_PAGES);
   assign ref_rd_addr  = req_page_ext[AW-1:0];
   assign stk_rd_addr  = count_m1[AW-1:0];
   assign req_fire     = req_ch.valid && req_ch.ready;
   // The result register can take a new result when it is empty or draining.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // ------------------------------------------------------------------
   // Execute datapath: works on the RAM read data in the execute state that
   // follows acceptance and decides the result and the write-backs.
   // ------------------------------------------------------------------
   logic [REF_BITS-1:0]   cnt_rd;
   logic [REF_BITS-1:0]   val_m;
   logic [MAXW-1:0]       val_ext;
   logic [PEXT_W-1:0]     pop_ext;
   logic                  pop_in_range;
   logic                  below_first;
   logic                  stack_full;
   logic                  stack_empty;

   logic [PAGE_OUT_W-1:0] res_page;
   logic [REF_BITS-1:0]   res_cnt;
   logic [MAXW-1:0]       res_cnt_ext;
   status_type            res_status;
   logic                  res_rel;
   logic                  op_ref_we;
   logic [AW-1:0]         op_ref_addr;
   logic [REF_BITS-1:0]   op_ref_data;
   logic                  op_stk_we;
   logic [CW-1:0]         op_count;

   assign cnt_rd       = in_range_ff ? ref_rd_data : '0;
   assign val_ext      = MAXW'(val_ff);
   assign val_m        = val_ext[REF_BITS-1:0];
   assign pop_ext      = PEXT_W'(stk_rd_data);
   assign pop_in_range = (32'(stk_rd_data) < NUM_PAGES);
   assign below_first  = (page_ff < PAGE_IN_W'(first_usable_page));
   assign stack_full   = (free_count_ff >= CW'(NUM_PAGES));
   assign stack_empty  = (free_count_ff == '0);
   assign res_cnt_ext  = MAXW'(res_cnt);

   always_comb begin
      res_page    = page_ff[PAGE_OUT_W-1:0];
      res_cnt     = '0;
      res_status  = STAT_OK;
      res_rel     = 1'b0;
      op_ref_we   = 1'b0;
      op_ref_addr = page_ff_ext[AW-1:0];
      op_ref_data = '0;
      op_stk_we   = 1'b0;
      op_count    = free_count_ff;
      case (kind_ff)
         KIND_ALLOC: begin
            if (stack_empty) begin
               // Nothing to hand out: report it and leave all state alone.
               res_page   = '0;
               res_status = STAT_NO_FREE;
            end else begin
               op_count    = count_m1;
               res_page    = stk_rd_data;
               res_cnt     = REF_BITS'(1);
               op_ref_we   = pop_in_range;
               op_ref_addr = pop_ext[AW-1:0];
               op_ref_data = REF_BITS'(1);
            end
         end
         KIND_FREE: begin
            if (cnt_rd > REF_BITS'(1)) begin
               // Page is still shared: only drop one reference.
               res_cnt     = cnt_rd - 1'b1;
               op_ref_we   = 1'b1;
               op_ref_data = cnt_rd - 1'b1;
            end else if (!in_range_ff || below_first) begin
               res_cnt    = cnt_rd;
               res_status = STAT_INVALID;
            end else if (stack_full) begin
               res_cnt    = cnt_rd;
               res_status = STAT_OVERFLOW;
            end else begin
               // Last reference gone: push the page and zero its count.
               op_stk_we = 1'b1;
               op_count  = free_count_ff + 1'b1;
               op_ref_we = 1'b1;
               res_rel   = 1'b1;
            end
         end
         KIND_SET: begin
            if (!in_range_ff) begin
               res_status = STAT_INVALID;
            end else begin
               res_cnt     = val_m;
               op_ref_we   = 1'b1;
               op_ref_data = val_m;
            end
         end
         default: begin
            // Get: report the stored count, or flag a page beyond the table.
            if (!in_range_ff) begin
               res_status = STAT_INVALID;
            end else begin
               res_cnt = ref_rd_data;
            end
         end
      endcase
   end

   assign stk_wr_addr = free_count_ff[AW-1:0];
   assign stk_wr_data = page_ff[PAGE_OUT_W-1:0];

   // ------------------------------------------------------------------
   // Sequencer: clearing pass after reset, then idle/execute per transaction.
   // ------------------------------------------------------------------
   logic commit;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      free_count_in = free_count_ff;
      req_ch.ready  = 1'b0;
      stk_rd_en     = 1'b0;
      ref_rd_en     = 1'b0;
      stk_wr_en     = 1'b0;
      ref_wr_en     = 1'b0;
      ref_wr_addr   = op_ref_addr;
      ref_wr_data   = op_ref_data;
      commit        = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            // One count entry zeroed per cycle.
            ref_wr_en   = 1'b1;
            ref_wr_addr = clr_addr_ff;
            ref_wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(NUM_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               stk_rd_en = 1'b1;
               ref_rd_en = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            // Hold here, read data frozen, until the result register has room.
            if (out_free) begin
               commit        = 1'b1;
               stk_wr_en     = op_stk_we;
               ref_wr_en     = op_ref_we;
               free_count_in = op_count;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         free_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff     <= req_ch.kind;
         page_ff     <= req_ch.page_index;
         val_ff      <= req_ch.ref_value;
         in_range_ff <= req_in_range;
      end
      if (commit) begin
         rsp_page_ff   <= res_page;
         rsp_cnt_ff    <= res_cnt_ext[REF_OUT_W-1:0];
         rsp_status_ff <= res_status;
         rsp_rel_ff    <= res_rel;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.page_out  = rsp_page_ff;
   assign rsp_ch.use_count = rsp_cnt_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.released  = rsp_rel_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CW'(NUM_PAGES))
      else $error("free count exceeds the number of pages");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_EXEC))
      else $error("accepted transaction did not move to execute");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!ref_wr_en && !stk_wr_en))
      else $error("RAM written while idle");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (commit && res_rel) |=> (free_count_ff == CW'($past(free_count_ff) + 1'b1)))
      else $error("release did not grow the free stack");

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      commit |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("result overwritten before it was taken");

endmodule

>>> sim/refcounted_page_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking bench for refcounted_page_allocator: random and directed requests
// against an in-bench allocator model. Depends on rpa_pkg, rpa_req_if, rpa_rsp_if.

// One predicted result transaction, in the field order of the result channel.
typedef struct packed {
   bit [14:0]            page;
   bit [7:0]             count;
   rpa_pkg::status_type  status;
   bit                   released;
} alloc_result_type;

// Shadow allocator: mirrors the free stack, its depth and the count table, and
// keeps the results still owed by the block in request order.
class allocator_book;
   localparam int PAGE_COUNT = 32768;

   bit [14:0]            stack_mem [PAGE_COUNT];
   bit [7:0]             counts [PAGE_COUNT];
   bit [15:0]            depth;
   bit [14:0]            first_usable;
   alloc_result_type     owed[$];
   bit [14:0]            last_page;
   rpa_pkg::status_type  last_status;
   int                   errors;

   function new();
      depth = 0;
      first_usable = 0;
      errors = 0;
   endfunction

   function int pending();
      return owed.size();
   endfunction

   function bit [7:0] count_of(bit [14:0] page);
      return counts[page];
   endfunction

   // Works out the result of one accepted request and updates the shadow state.
   function void note_request(rpa_pkg::kind_type kind, bit [15:0] page, bit [7:0] value);
      alloc_result_type r;
      bit               in_range;
      bit [7:0]         cnt;
      in_range   = page < PAGE_COUNT;
      r.page     = page[14:0];
      r.count    = 8'd0;
      r.status   = rpa_pkg::STAT_OK;
      r.released = 1'b0;
      case (kind)
         rpa_pkg::KIND_ALLOC: begin
            if (depth == 0) begin
               r.page   = 15'd0;
               r.status = rpa_pkg::STAT_NO_FREE;
            end else begin
               depth--;
               r.page         = stack_mem[depth];
               counts[r.page] = 8'd1;
               r.count        = 8'd1;
            end
         end
         rpa_pkg::KIND_FREE: begin
            cnt = in_range ? counts[page[14:0]] : 8'd0;
            if (cnt > 1) begin
               counts[page[14:0]] = cnt - 8'd1;
               r.count            = cnt - 8'd1;
            end else if (!in_range || page < first_usable) begin
               r.count  = cnt;
               r.status = rpa_pkg::STAT_INVALID;
            end else if (depth >= PAGE_COUNT) begin
               r.count  = cnt;
               r.status = rpa_pkg::STAT_OVERFLOW;
            end else begin
               stack_mem[depth]   = page[14:0];
               depth++;
               counts[page[14:0]] = 8'd0;
               r.released         = 1'b1;
            end
         end
         default: begin
            if (!in_range) begin
               r.status = rpa_pkg::STAT_INVALID;
            end else if (kind == rpa_pkg::KIND_SET) begin
               counts[page[14:0]] = value;
               r.count            = value;
            end else begin
               r.count = counts[page[14:0]];
            end
         end
      endcase
      last_page   = r.page;
      last_status = r.status;
      owed.push_back(r);
   endfunction

   // Compares one accepted result with the oldest owed one, field by field.
   function void check_result(bit [14:0] page, bit [7:0] count,
                              rpa_pkg::status_type status, bit released);
      alloc_result_type r;
      if (owed.size() == 0) begin
         $error("result with nothing outstanding: page_out %0d status %0d", page, status);
         errors++;
         return;
      end
      r = owed.pop_front();
      if (page != r.page) begin
         $error("page_out: expected %0d, got %0d", r.page, page);
         errors++;
      end
      if (count != r.count) begin
         $error("use_count: expected %0d, got %0d", r.count, count);
         errors++;
      end
      if (status != r.status) begin
         $error("status: expected %0d, got %0d", r.status, status);
         errors++;
      end
      if (released != r.released) begin
         $error("released: expected %0d, got %0d", r.released, released);
         errors++;
      end
   endfunction
endclass

module refcounted_page_allocator_test;
   import rpa_pkg::*;

   localparam int PAGE_COUNT = 32768;
   // The longest correct stretch without any transaction is the clearing pass
   // after reset, which clears one page per cycle. Allow several times that.
   localparam int QUIET_LIMIT = 4 * PAGE_COUNT;

   logic clock;
   logic reset;

   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   rpa_req_if req_bus ();
   rpa_rsp_if rsp_bus ();

   allocator_book book;

   // Idling switch shared by the sender and the receiver: when it is clear both
   // sides run back to back. hold_request asks the receiver for one long stall.
   bit idle_on      = 1'b1;
   bit hold_request = 1'b0;

   // Pages the bench believes are handed out, so that most frees, sets and gets
   // aim at live pages instead of noise.
   bit [14:0] held[$];

   refcounted_page_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Writes the first usable page register through a setup and an access cycle.
   // Called right after a rising edge; returns at the edge that did the write.
   task automatic write_first_usable(bit [14:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * CSR_IDX_FIRST_USABLE);
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      book.first_usable = value;
   endtask

   // Offers one request after a random gap and waits for its transaction. The
   // valid line stays high into the next request when that one has no gap.
   task automatic send_request(kind_type kind, bit [15:0] page, bit [7:0] value);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.page_index <= page;
      req_bus.ref_value  <= value;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      book.note_request(kind, page, value);
   endtask

   // Lowers valid and waits until every owed result has come back, then adds a
   // margin so that the block is idle.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One random request. Most of them are allocations and frees, sets and gets
   // of live pages; the rest feed random usable pages to the stack or are noise
   // with every field random, out-of-range pages included.
   task automatic random_request();
      int unsigned pick;
      int unsigned slot;
      bit [15:0]   page;
      bit [7:0]    value;
      pick = $urandom_range(0, 99);
      if (held.size() == 0 && pick >= 30 && pick < 65) pick = 0;
      slot  = (held.size() == 0) ? 0 : $urandom_range(0, held.size() - 1);
      value = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      if (pick < 30) begin
         // The page field is ignored by an allocation, so it carries noise.
         send_request(KIND_ALLOC, 16'($urandom), value);
         if (book.last_status == STAT_OK) held.push_back(book.last_page);
      end else if (pick < 55) begin
         page = {1'b0, held[slot]};
         send_request(KIND_FREE, page, value);
         if (book.count_of(page[14:0]) == 0) held.delete(slot);
      end else if (pick < 65) begin
         send_request(KIND_SET, {1'b0, held[slot]}, value);
      end else if (pick < 75) begin
         if (held.size() > 0 && $urandom_range(0, 1) == 1) page = {1'b0, held[slot]};
         else page = 16'($urandom);
         send_request(KIND_GET, page, value);
      end else if (pick < 85) begin
         page = 16'($urandom_range(book.first_usable, PAGE_COUNT - 1));
         send_request(KIND_FREE, page, value);
      end else begin
         send_request(kind_type'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      end
   endtask

   // A run of random requests, with idling switched off for some blocks of a
   // hundred so that back-to-back traffic is covered too.
   task automatic random_phase(int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
         random_request();
      end
      idle_on = 1'b1;
   endtask

   // Result side: random stalls, one long stall on request so
   // that the block backs up and stalls its request side, then the check.
   // Nothing is sampled until reset has been released.
   initial begin
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = idle_on ? $urandom_range(0, 10) : 0;
         if (hold_request) begin
            hold_request = 1'b0;
            stall        = 400;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         book.check_result(rsp_bus.page_out, rsp_bus.use_count, rsp_bus.status,
                           rsp_bus.released);
      end
   end

   // Watchdog: any transaction on either channel or a register write counts as
   // progress. A long quiet stretch means the block has hung.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      bit [14:0] base;
      book = new();
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.kind       <= KIND_ALLOC;
      req_bus.page_index <= '0;
      req_bus.ref_value  <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The register may be written during the clearing pass; requests simply
      // wait until the count table is clear.
      write_first_usable(15'd16);

      // Directed cases: empty stack, bad pages on both sides of the valid range,
      // out-of-range set and get, counts at both ends, decrement, double free,
      // and a free of a page below the first usable one that still has users.
      send_request(KIND_ALLOC, 16'd0,     8'd0);
      send_request(KIND_GET,   16'd0,     8'd0);
      send_request(KIND_FREE,  16'd5,     8'd0);
      send_request(KIND_FREE,  16'hFFFF,  8'd0);
      send_request(KIND_SET,   16'd40000, 8'd7);
      send_request(KIND_GET,   16'd32768, 8'd0);
      send_request(KIND_FREE,  16'd16,    8'd0);
      send_request(KIND_FREE,  16'd32767, 8'd0);
      send_request(KIND_FREE,  16'd17,    8'd0);
      send_request(KIND_ALLOC, 16'd0,     8'd0);
      send_request(KIND_ALLOC, 16'd0,     8'd0);
      send_request(KIND_SET,   16'd32767, 8'd255);
      send_request(KIND_FREE,  16'd32767, 8'd0);
      send_request(KIND_SET,   16'd32767, 8'd2);
      send_request(KIND_FREE,  16'd32767, 8'd0);
      send_request(KIND_FREE,  16'd32767, 8'd0);
      send_request(KIND_FREE,  16'd32767, 8'd0);
      send_request(KIND_SET,   16'd0,     8'd0);
      send_request(KIND_GET,   16'd32767, 8'd0);
      send_request(KIND_SET,   16'd100,   8'hAA);
      send_request(KIND_SET,   16'd101,   8'h55);
      send_request(KIND_FREE,  16'd15,    8'd0);
      send_request(KIND_SET,   16'd15,    8'd3);
      send_request(KIND_FREE,  16'd15,    8'd0);
      send_request(KIND_GET,   16'd15,    8'd0);
      drain();

      // Startup as software does it: free a block of usable pages, then mixed
      // traffic. Partway in, the receiver stalls for a long stretch.
      for (int p = 16; p < 80; p++) send_request(KIND_FREE, 16'(p), 8'd0);
      random_phase(200);
      hold_request = 1'b1;
      random_phase(600);
      drain();

      // Every page is usable, page zero included.
      write_first_usable(15'd0);
      random_phase(500);
      drain();

      // Only the top page is usable; nearly every push is refused.
      write_first_usable(15'd32767);
      random_phase(250);
      drain();

      // A random floor for usable pages, a few frees and an allocation around
      // it, then mixed traffic.
      base = 15'($urandom_range(1, 2000));
      write_first_usable(base);
      send_request(KIND_FREE,  16'd32767, 8'd0);
      send_request(KIND_ALLOC, 16'd0,     8'd0);
      send_request(KIND_FREE,  16'd32767, 8'd0);
      send_request(KIND_FREE,  16'(base), 8'd0);
      random_phase(250);
      drain();

      if (book.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/rpa_pkg.sv
rtl/rpa_req_if.sv
rtl/rpa_rsp_if.sv
rtl/rpa_ram.sv
rtl/rpa_csr.sv
rtl/refcounted_page_allocator.sv
sim/refcounted_page_allocator_test.sv
